/* sv/mmcs_pkg.sv */
`timescale 1ns / 1ps

package mmcs_pkg;

   // pixel geometry
   localparam int PIXEL_BITS = 8;
   localparam int DIV_STEPS  = PIXEL_BITS;
   localparam int CNT_BITS   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int NUM_BITS   = 2 * PIXEL_BITS;

   localparam logic [PIXEL_BITS-1:0] PIX_MAX  = {PIXEL_BITS{1'b1}};
   localparam logic [PIXEL_BITS-1:0] PIX_ZERO = {PIXEL_BITS{1'b0}};

   // request op codes
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_MAP  = 1'b1;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [CNT_BITS-1:0]   count_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic scan;           // scan word accepted, update min/max
      logic start;          // map word accepted, load divider
      logic step;           // one restoring divide step
      logic out_load;       // load result word into output register
      logic out_from_step;  // take quotient from this cycle's final step
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;       // output register empty or being drained
   } status_type;

endpackage

/* sv/mmcs_ctrl.sv */
`timescale 1ns / 1ps

module mmcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   input  mmcs_pkg::status_type status,
   output mmcs_pkg::cmd_type    cmd
);

   mmcs_pkg::state_type state_ff, state_in;
   mmcs_pkg::count_type cnt_ff, cnt_in;

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmcs_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      logic accept;
      logic last_step;
      accept    = 1'b0;
      last_step = (cnt_ff == mmcs_pkg::count_type'(mmcs_pkg::DIV_STEPS - 1));
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         mmcs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            cnt_in    = '0;
            if (accept && (req_op == mmcs_pkg::OP_SCAN)) begin
               cmd.scan = 1'b1;
            end
            if (accept && (req_op == mmcs_pkg::OP_MAP)) begin
               cmd.start = 1'b1;
               state_in  = mmcs_pkg::ST_DIV;
            end
         end
         mmcs_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (last_step) begin
               cnt_in = '0;
               if (status.out_free) begin
                  cmd.out_load      = 1'b1;
                  cmd.out_from_step = 1'b1;
                  state_in          = mmcs_pkg::ST_IDLE;
               end else begin
                  state_in = mmcs_pkg::ST_DONE;
               end
            end
         end
         mmcs_pkg::ST_DONE: begin
            // result waits for a free output register
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = mmcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmcs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/mmcs_dp.sv */
`timescale 1ns / 1ps

module mmcs_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mmcs_pkg::pixel_type  req_pixel,
   input  logic                 req_first,
   input  logic                 req_last,
   input  mmcs_pkg::cmd_type    cmd,
   output mmcs_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mmcs_pkg::pixel_type  rsp_stretched,
   output logic                 rsp_end_of_frame
);

   mmcs_pkg::pixel_type min_ff, min_in;
   mmcs_pkg::pixel_type max_ff, max_in;

   // divider registers
   mmcs_pkg::pixel_type rem_ff, rem_in;
   mmcs_pkg::pixel_type num_lo_ff, num_lo_in;
   mmcs_pkg::pixel_type den_ff, den_in;
   mmcs_pkg::pixel_type quo_ff, quo_in;
   logic                special_ff, special_in;
   mmcs_pkg::pixel_type special_val_ff, special_val_in;
   logic                last_ff, last_in;

   // output register
   logic                out_valid_ff, out_valid_in;
   mmcs_pkg::pixel_type out_data_ff, out_data_in;
   logic                out_eof_ff, out_eof_in;

   // running min and max over the scan pass
   always_comb begin
      mmcs_pkg::pixel_type lo;
      mmcs_pkg::pixel_type hi;
      lo     = req_first ? mmcs_pkg::PIX_MAX  : min_ff;
      hi     = req_first ? mmcs_pkg::PIX_ZERO : max_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (cmd.scan) begin
         min_in = (req_pixel < lo) ? req_pixel : lo;
         max_in = (req_pixel > hi) ? req_pixel : hi;
      end
   end

   // divider load and restoring step
   always_comb begin
      mmcs_pkg::pixel_type                 diff;
      logic [mmcs_pkg::NUM_BITS-1:0]       num;
      logic [mmcs_pkg::PIXEL_BITS:0]       trial;
      logic                                ge;
      diff  = req_pixel - min_ff;
      num   = {diff, mmcs_pkg::PIX_ZERO} - {mmcs_pkg::PIX_ZERO, diff};
      trial = {rem_ff, num_lo_ff[mmcs_pkg::PIXEL_BITS-1]};
      ge    = (trial >= {1'b0, den_ff});

      rem_in         = rem_ff;
      num_lo_in      = num_lo_ff;
      den_in         = den_ff;
      quo_in         = quo_ff;
      special_in     = special_ff;
      special_val_in = special_val_ff;
      last_in        = last_ff;

      if (cmd.start) begin
         // numerator is pix_max * (p - min), formed as shift minus one copy
         rem_in     = num[mmcs_pkg::NUM_BITS-1:mmcs_pkg::PIXEL_BITS];
         num_lo_in  = num[mmcs_pkg::PIXEL_BITS-1:0];
         den_in     = max_ff - min_ff;
         quo_in     = '0;
         last_in    = req_last;
         special_in = 1'b1;
         if (max_ff <= min_ff || req_pixel <= min_ff) begin
            special_val_in = mmcs_pkg::PIX_ZERO;
         end else if (req_pixel >= max_ff) begin
            special_val_in = mmcs_pkg::PIX_MAX;
         end else begin
            special_in     = 1'b0;
            special_val_in = mmcs_pkg::PIX_ZERO;
         end
      end else if (cmd.step) begin
         rem_in    = ge ? mmcs_pkg::pixel_type'(trial - {1'b0, den_ff})
                        : trial[mmcs_pkg::PIXEL_BITS-1:0];
         num_lo_in = {num_lo_ff[mmcs_pkg::PIXEL_BITS-2:0], 1'b0};
         quo_in    = {quo_ff[mmcs_pkg::PIXEL_BITS-2:0], ge};
      end
   end

   // output word register
   always_comb begin
      mmcs_pkg::pixel_type quo_sel;
      quo_sel      = cmd.out_from_step ? quo_in : quo_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_eof_in   = out_eof_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_data_in  = special_ff ? special_val_ff : quo_sel;
         out_eof_in   = last_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= mmcs_pkg::PIX_MAX;
         max_ff       <= mmcs_pkg::PIX_ZERO;
         out_valid_ff <= 1'b0;
      end else begin
         min_ff       <= min_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      num_lo_ff      <= num_lo_in;
      den_ff         <= den_in;
      quo_ff         <= quo_in;
      special_ff     <= special_in;
      special_val_ff <= special_val_in;
      last_ff        <= last_in;
      out_data_ff    <= out_data_in;
      out_eof_ff     <= out_eof_in;
   end

   assign status.out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid        = out_valid_ff;
   assign rsp_stretched    = out_data_ff;
   assign rsp_end_of_frame = out_eof_ff;

endmodule

/* sv/min_max_contrast_stretch.sv */
`timescale 1ns / 1ps
// Min/max linear contrast stretch of 8-bit grey pixels, two passes per frame.
// Request channel (req_*): one pixel word per handshake. req_op selects the
// pass: scan words widen the running min/max (req_first restarts them) and
// give no response; map words give one response word each.
// Response channel (rsp_*): rsp_stretched = floor(255*(p-min)/(max-min)),
// saturated to 0..255, or 0 for an empty or flat range; rsp_end_of_frame
// copies req_last of the map word.
// Sequence: a scan word ends in its accept cycle; a map word takes an accept
// cycle plus 8 steps of the radix-2 restoring divider, one quotient bit per
// step. rsp_valid rises at the edge that registers the last step if the
// output register is free.
// Only one word is in the divider at a time; req_ready is high while the
// divider is idle.
// Stall: the response sits in an output register, so new words are accepted
// while it waits; a finished quotient holds in the divider until that
// register frees, with req_ready low.
// Reset (synchronous, active high): min = 255, max = 0, no response pending.
module min_max_contrast_stretch (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  mmcs_pkg::pixel_type req_pixel,
   input  logic                req_first,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mmcs_pkg::pixel_type rsp_stretched,
   output logic                rsp_end_of_frame
);

   mmcs_pkg::cmd_type    cmd;
   mmcs_pkg::status_type status;

   // sequencer
   mmcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // min/max, divider and output register
   mmcs_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_pixel        (req_pixel),
      .req_first        (req_first),
      .req_last         (req_last),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_stretched    (rsp_stretched),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

/* sv/mmcs_checker.sv */
`timescale 1ns / 1ps

module mmcs_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_op,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input mmcs_pkg::pixel_type rsp_stretched
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stretched))
      else $error("response word dropped or changed while stalled");

   // a map word occupies the divider on the next cycle
   a_map_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == mmcs_pkg::OP_MAP |=> !req_ready)
      else $error("request taken while divider busy");

   // a scan word leaves the request channel ready on the next cycle
   a_scan_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == mmcs_pkg::OP_SCAN |=> req_ready)
      else $error("scan word stalled the request channel");

   // no response word right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind min_max_contrast_stretch mmcs_checker u_mmcs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_op        (req_op),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_stretched (rsp_stretched)
);

/* tb/mmcs_checker.sv */
`timescale 1ns / 1ps

module mmcs_scoreboard (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_op,
   input  mmcs_pkg::pixel_type req_pixel,
   input  logic                req_first,
   input  logic                req_last,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  mmcs_pkg::pixel_type rsp_stretched,
   input  logic                rsp_end_of_frame,
   output int                  fail_count,
   output int                  words_due,
   output int                  scan_words,
   output int                  map_words,
   output int                  flat_maps
);

   // one predicted response word
   typedef struct {
      mmcs_pkg::pixel_type stretched;
      logic                end_of_frame;
   } mapped_word_type;

   mapped_word_type mapped_q[$];
   mapped_word_type due_word;
   mapped_word_type new_word;

   // running range, mirrors the block's scan state
   mmcs_pkg::pixel_type scan_lo;
   mmcs_pkg::pixel_type scan_hi;

   // stretch of one pixel against the scanned range, saturated at both ends
   function automatic mmcs_pkg::pixel_type stretch_level(mmcs_pkg::pixel_type pix,
                                                         mmcs_pkg::pixel_type lo,
                                                         mmcs_pkg::pixel_type hi);
      logic [mmcs_pkg::NUM_BITS-1:0] num;
      logic [mmcs_pkg::NUM_BITS-1:0] den;
      logic [mmcs_pkg::NUM_BITS-1:0] quo;
      if (hi <= lo) return mmcs_pkg::PIX_ZERO;
      if (pix <= lo) return mmcs_pkg::PIX_ZERO;
      if (pix >= hi) return mmcs_pkg::PIX_MAX;
      num = {mmcs_pkg::PIX_ZERO, mmcs_pkg::PIX_MAX};
      num = num * {mmcs_pkg::PIX_ZERO, mmcs_pkg::pixel_type'(pix - lo)};
      den = {mmcs_pkg::PIX_ZERO, mmcs_pkg::pixel_type'(hi - lo)};
      quo = num / den;
      return quo[mmcs_pkg::PIXEL_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         scan_words = 0;
         map_words  = 0;
         flat_maps  = 0;
         scan_lo    = mmcs_pkg::PIX_MAX;
         scan_hi    = mmcs_pkg::PIX_ZERO;
         mapped_q.delete();
      end else begin
         // response side: compare against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (mapped_q.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %0d eof %0b",
                        $time, rsp_stretched, rsp_end_of_frame);
               fail_count++;
            end else begin
               due_word = mapped_q.pop_front();
               if (rsp_stretched !== due_word.stretched) begin
                  $display("%0t: stretched mismatch, expected %0d, actual %0d",
                           $time, due_word.stretched, rsp_stretched);
                  fail_count++;
               end
               if (rsp_end_of_frame !== due_word.end_of_frame) begin
                  $display("%0t: end_of_frame mismatch, expected %0b, actual %0b",
                           $time, due_word.end_of_frame, rsp_end_of_frame);
                  fail_count++;
               end
            end
         end
         // request side: update range or predict a response
         if (req_valid && req_ready) begin
            if (req_op == mmcs_pkg::OP_SCAN) begin
               scan_words++;
               if (req_first) begin
                  scan_lo = mmcs_pkg::PIX_MAX;
                  scan_hi = mmcs_pkg::PIX_ZERO;
               end
               if (req_pixel < scan_lo) scan_lo = req_pixel;
               if (req_pixel > scan_hi) scan_hi = req_pixel;
            end else begin
               map_words++;
               if (scan_hi <= scan_lo) flat_maps++;
               new_word.stretched    = stretch_level(req_pixel, scan_lo, scan_hi);
               new_word.end_of_frame = req_last;
               mapped_q.push_back(new_word);
            end
         end
      end
      words_due = mapped_q.size();
   end

endmodule

/* tb/tb_min_max_contrast_stretch.sv */
`timescale 1ns / 1ps

module tb_min_max_contrast_stretch;

   localparam int RANDOM_WORDS = 950;
   localparam int HOLD_CYCLES  = 80;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_op;
   mmcs_pkg::pixel_type req_pixel;
   logic                req_first;
   logic                req_last;
   logic                rsp_valid;
   logic                rsp_ready;
   mmcs_pkg::pixel_type rsp_stretched;
   logic                rsp_end_of_frame;

   int fail_count;
   int words_due;
   int scan_words;
   int map_words;
   int flat_maps;

   int words_sent;
   int burst_left;
   int frames_sent;
   int cycle_no;
   int hold_left;
   int holds_done;
   rx_mode_type rx_mode;

   min_max_contrast_stretch i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pixel        (req_pixel),
      .req_first        (req_first),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_stretched    (rsp_stretched),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   mmcs_scoreboard i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pixel        (req_pixel),
      .req_first        (req_first),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_stretched    (rsp_stretched),
      .rsp_end_of_frame (rsp_end_of_frame),
      .fail_count       (fail_count),
      .words_due        (words_due),
      .scan_words       (scan_words),
      .map_words        (map_words),
      .flat_maps        (flat_maps)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // offer one word, wait for its handshake, then maybe end the burst
   task automatic send_word(logic op, mmcs_pkg::pixel_type pix, logic first, logic last);
      int gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_op    = op;
      req_pixel = pix;
      req_first = first;
      req_last  = last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (op == mmcs_pkg::OP_MAP && last) frames_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // one scan pass over a random range followed by one map pass
   task automatic send_frame();
      int                  n_scan;
      int                  n_map;
      int                  shape;
      mmcs_pkg::pixel_type lo;
      mmcs_pkg::pixel_type hi;
      mmcs_pkg::pixel_type pix;
      logic                broken;
      n_scan = $urandom_range(1, 12);
      n_map  = $urandom_range(1, 12);
      shape  = $urandom_range(0, 3);
      lo     = mmcs_pkg::pixel_type'($urandom_range(0, 255));
      case (shape)
         0: hi = mmcs_pkg::pixel_type'($urandom_range(lo, 255));
         1: hi = (lo > 247) ? mmcs_pkg::PIX_MAX
                            : mmcs_pkg::pixel_type'(lo + $urandom_range(0, 8));
         2: hi = lo;
         default: begin
            lo = mmcs_pkg::PIX_ZERO;
            hi = mmcs_pkg::PIX_MAX;
         end
      endcase
      // a few frames skip the restart and carry the old range on
      broken = ($urandom_range(0, 15) == 0);
      for (int i = 0; i < n_scan; i++) begin
         if (i == 0) pix = lo;
         else if (i == 1) pix = hi;
         else pix = mmcs_pkg::pixel_type'($urandom_range(lo, hi));
         send_word(mmcs_pkg::OP_SCAN, pix, (i == 0) && !broken, $urandom_range(0, 7) == 0);
      end
      for (int i = 0; i < n_map; i++) begin
         case ($urandom_range(0, 5))
            0: pix = mmcs_pkg::pixel_type'($urandom_range(0, 255));
            1: pix = ($urandom_range(0, 1) == 1) ? mmcs_pkg::PIX_MAX : mmcs_pkg::PIX_ZERO;
            2: pix = ($urandom_range(0, 1) == 1) ? lo : hi;
            default: pix = mmcs_pkg::pixel_type'($urandom_range(lo, hi));
         endcase
         send_word(mmcs_pkg::OP_MAP, pix, $urandom_range(0, 7) == 0, i == n_map - 1);
      end
   endtask

   // response side stall pattern, with a couple of long hold-offs
   initial begin
      rsp_ready  = 1'b0;
      cycle_no   = 0;
      hold_left  = 0;
      holds_done = 0;
      rx_mode    = RX_OPEN;
      forever begin
         @(negedge clock);
         cycle_no++;
         if (cycle_no % 64 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
         if (cycle_no == 1500 || cycle_no == 9000) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            case (rx_mode)
               RX_OPEN:     rsp_ready = 1'b1;
               RX_COIN:     rsp_ready = logic'($urandom_range(0, 1));
               RX_SPARSE:   rsp_ready = ($urandom_range(0, 3) == 0);
               RX_PERIODIC: rsp_ready = ((cycle_no % 7) >= 3);
               default:     rsp_ready = 1'b1;
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_op     = mmcs_pkg::OP_SCAN;
      req_pixel  = mmcs_pkg::PIX_ZERO;
      req_first  = 1'b0;
      req_last   = 1'b0;
      words_sent = 0;
      frames_sent = 0;
      burst_left = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // map before any scan sees the empty reset range
      send_word(mmcs_pkg::OP_MAP, 8'd128, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, mmcs_pkg::PIX_ZERO, 1'b0, 1'b1);
      // ordinary range, last in scan pass is ignored
      send_word(mmcs_pkg::OP_SCAN, 8'd100, 1'b1, 1'b0);
      send_word(mmcs_pkg::OP_SCAN, 8'd40, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_SCAN, 8'd200, 1'b0, 1'b1);
      send_word(mmcs_pkg::OP_SCAN, 8'd150, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, 8'd40, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, 8'd100, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, 8'd200, 1'b0, 1'b0);
      // below and above the scanned range saturate
      send_word(mmcs_pkg::OP_MAP, 8'd10, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, 8'd250, 1'b0, 1'b0);
      // first on a map word must not restart the range
      send_word(mmcs_pkg::OP_MAP, 8'd120, 1'b1, 1'b0);
      send_word(mmcs_pkg::OP_MAP, 8'd199, 1'b0, 1'b1);
      // flat range
      send_word(mmcs_pkg::OP_SCAN, 8'd77, 1'b1, 1'b0);
      send_word(mmcs_pkg::OP_MAP, 8'd77, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, mmcs_pkg::PIX_MAX, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, mmcs_pkg::PIX_ZERO, 1'b0, 1'b1);
      // full range
      send_word(mmcs_pkg::OP_SCAN, mmcs_pkg::PIX_MAX, 1'b1, 1'b0);
      send_word(mmcs_pkg::OP_SCAN, mmcs_pkg::PIX_ZERO, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, mmcs_pkg::PIX_ZERO, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, mmcs_pkg::PIX_MAX, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, 8'd128, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, 8'd1, 1'b0, 1'b1);
      // narrowest non-flat range
      send_word(mmcs_pkg::OP_SCAN, mmcs_pkg::PIX_ZERO, 1'b1, 1'b0);
      send_word(mmcs_pkg::OP_SCAN, 8'd1, 1'b0, 1'b0);
      send_word(mmcs_pkg::OP_MAP, 8'd1, 1'b0, 1'b1);

      // random frames with some loose noise words between them
      while (words_sent < RANDOM_WORDS + 26) begin
         if ($urandom_range(0, 9) == 0)
            send_word(logic'($urandom_range(0, 1)),
                      mmcs_pkg::pixel_type'($urandom_range(0, 255)),
                      logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
         else
            send_frame();
      end
      @(negedge clock);
      req_valid = 1'b0;

      // drain, then let a stray word show up if there is one
      while (words_due != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d scan words and %0d map words in %0d frames",
               scan_words, map_words, frames_sent);
      $display("%0d maps on a flat or empty range, %0d long response hold-offs",
               flat_maps, holds_done);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("%0t: watchdog expired with %0d words outstanding", $time, words_due);
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* min_max_contrast_stretch.f */
sv/mmcs_pkg.sv
sv/mmcs_ctrl.sv
sv/mmcs_dp.sv
sv/min_max_contrast_stretch.sv
sv/mmcs_checker.sv
tb/mmcs_checker.sv
tb/tb_min_max_contrast_stretch.sv
